// ===== sv/gwd_pkg.sv =====
package gwd_pkg;

  localparam int RING_DEPTH_DEF = 32;

  localparam int COUNT_W    = 13;
  localparam int MOD_W      = 14;
  localparam int SPEED_W    = 8;
  localparam int DIR_W      = 12;
  localparam int SLOT_OUT_W = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 14;

  // ring entry: {sent mark, direction, speed}
  localparam int ENTRY_W = 1 + DIR_W + SPEED_W;

  localparam logic [SPEED_W-1:0] MIN_START     = 8'd150;
  localparam logic [SPEED_W-1:0] THRESH_RESET  = 8'd10;
  localparam logic [MOD_W-1:0]   MODULUS_RESET = 14'd8192;

  localparam logic [CFG_IDX_W-1:0] REG_GUST_THRESHOLD  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTER_MODULUS = 1'd1;

  localparam logic OP_RECORD   = 1'b0;
  localparam logic OP_EVALUATE = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic rec_write;   // store the accepted sample
    logic clr_result;  // result defaults to no gust
    logic scan_init;   // reset min, max and scan counter
    logic scan_rd;     // read ring at scan counter
    logic fetch_rd;    // read ring at maximum position
    logic decide;      // threshold test and sent mark update
    logic load_out;    // move result into output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ring_full;
    logic cnt_last;
  } status_t;

endpackage

// ===== sv/gwd_ram.sv =====
module gwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/gwd_ctrl.sv =====
module gwd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            opcode_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  gwd_pkg::status_t status_i,
  output gwd_pkg::cmd_t    cmd_o
);
  import gwd_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_DRAIN  = 6'b000100,
    ST_FETCH  = 6'b001000,
    ST_DECIDE = 6'b010000,
    ST_LOAD   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.clr_result = 1'b1;
          if (opcode_i == OP_RECORD) begin
            cmd_o.rec_write = 1'b1;
            state_d         = ST_LOAD;
          end else if (!status_i.ring_full) begin
            state_d = ST_LOAD;
          end else begin
            cmd_o.scan_init = 1'b1;
            state_d         = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (status_i.cnt_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FETCH;
      end
      ST_FETCH: begin
        cmd_o.fetch_rd = 1'b1;
        state_d        = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/gwd_datapath.sv =====
module gwd_datapath #(
  parameter int RING_DEPTH = gwd_pkg::RING_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [gwd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gwd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [gwd_pkg::COUNT_W-1:0]    counter_reading_i,
  input  logic [gwd_pkg::DIR_W-1:0]      direction_reading_i,
  input  gwd_pkg::cmd_t                  cmd_i,
  output gwd_pkg::status_t               status_o,
  output logic                           gust_found_o,
  output logic [gwd_pkg::SPEED_W-1:0]    gust_speed_o,
  output logic [gwd_pkg::DIR_W-1:0]      gust_direction_o,
  output logic [gwd_pkg::SLOT_OUT_W-1:0] gust_slot_o
);
  import gwd_pkg::*;

  localparam int SLOT_W = $clog2(RING_DEPTH);
  localparam int PW     = (SLOT_W > SLOT_OUT_W) ? SLOT_W : SLOT_OUT_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_DEPTH - 1);

  // configuration
  logic [SPEED_W-1:0] thr_q;
  logic [MOD_W-1:0]   mod_q;

  // sample bookkeeping
  logic [COUNT_W-1:0] last_count_q;
  logic [SLOT_W-1:0]  write_slot_q;
  logic               ring_full_q;

  // scan
  logic [SLOT_W-1:0]  cnt_q;
  logic               acc_vld_q;
  logic [SLOT_W-1:0]  acc_idx_q;
  logic [SPEED_W-1:0] lo_q, hi_q;
  logic [SLOT_W-1:0]  pos_q;
  logic               found_q;

  // result and output register
  logic               res_found_q;
  logic [SPEED_W-1:0] res_speed_q;
  logic [DIR_W-1:0]   res_dir_q;
  logic [SLOT_W-1:0]  res_slot_q;
  logic               out_found_q;
  logic [SPEED_W-1:0] out_speed_q;
  logic [DIR_W-1:0]   out_dir_q;
  logic [SLOT_OUT_W-1:0] out_slot_q;
  logic [PW-1:0]      res_slot_ext;

  // ring memory
  logic               ram_we;
  logic [SLOT_W-1:0]  ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [SPEED_W-1:0] rd_speed;
  logic [DIR_W-1:0]   rd_dir;
  logic               rd_sent;

  logic [SPEED_W-1:0] inc;
  logic [SPEED_W:0]   lo_plus_thr;
  logic               report;

  assign rd_speed = ram_rdata[SPEED_W-1:0];
  assign rd_dir   = ram_rdata[SPEED_W +: DIR_W];
  assign rd_sent  = ram_rdata[ENTRY_W-1];

  // only the low byte of the increment survives, so work in 8 bits
  always_comb begin
    inc = counter_reading_i[SPEED_W-1:0] - last_count_q[SPEED_W-1:0];
    if (last_count_q > counter_reading_i) begin
      inc = inc + mod_q[SPEED_W-1:0];
    end
  end

  assign lo_plus_thr = {1'b0, lo_q} + {1'b0, thr_q};
  assign report = found_q && ({1'b0, hi_q} >= lo_plus_thr) && !rd_sent;

  assign ram_we    = cmd_i.rec_write || (cmd_i.decide && report);
  assign ram_waddr = cmd_i.rec_write ? write_slot_q : pos_q;
  assign ram_wdata = cmd_i.rec_write ? {1'b0, direction_reading_i, inc}
                                     : {1'b1, rd_dir, rd_speed};
  assign ram_raddr = cmd_i.fetch_rd ? pos_q : cnt_q;

  gwd_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q        <= THRESH_RESET;
      mod_q        <= MODULUS_RESET;
      last_count_q <= '0;
      write_slot_q <= '0;
      ring_full_q  <= 1'b0;
      cnt_q        <= '0;
      acc_vld_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_GUST_THRESHOLD:  thr_q <= cfg_data_i[SPEED_W-1:0];
          REG_COUNTER_MODULUS: mod_q <= cfg_data_i[MOD_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.rec_write) begin
        last_count_q <= counter_reading_i;
        if (write_slot_q == LAST_SLOT) begin
          write_slot_q <= '0;
          ring_full_q  <= 1'b1;
        end else begin
          write_slot_q <= write_slot_q + 1'b1;
        end
      end
      if (cmd_i.scan_init) begin
        cnt_q <= '0;
      end else if (cmd_i.scan_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end
      acc_vld_q <= cmd_i.scan_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_idx_q <= cnt_q;
    if (cmd_i.scan_init) begin
      lo_q    <= MIN_START;
      hi_q    <= '0;
      pos_q   <= '0;
      found_q <= 1'b0;
    end else if (acc_vld_q) begin
      if (rd_speed < lo_q) begin
        lo_q <= rd_speed;
      end
      // strict compare keeps the first maximum
      if (rd_speed > hi_q) begin
        hi_q    <= rd_speed;
        pos_q   <= acc_idx_q;
        found_q <= 1'b1;
      end
    end
    if (cmd_i.clr_result) begin
      res_found_q <= 1'b0;
      res_speed_q <= '0;
      res_dir_q   <= '0;
      res_slot_q  <= '0;
    end else if (cmd_i.decide && report) begin
      res_found_q <= 1'b1;
      res_speed_q <= rd_speed;
      res_dir_q   <= rd_dir;
      res_slot_q  <= pos_q;
    end
    if (cmd_i.load_out) begin
      out_found_q <= res_found_q;
      out_speed_q <= res_speed_q;
      out_dir_q   <= res_dir_q;
      out_slot_q  <= res_slot_ext[SLOT_OUT_W-1:0];
    end
  end

  assign res_slot_ext = PW'(res_slot_q);

  assign status_o.ring_full = ring_full_q;
  assign status_o.cnt_last  = (cnt_q == LAST_SLOT);

  assign gust_found_o     = out_found_q;
  assign gust_speed_o     = out_speed_q;
  assign gust_direction_o = out_dir_q;
  assign gust_slot_o      = out_slot_q;

endmodule

// ===== sv/wind_gust_window_detector_core.sv =====
// gust detector over a ring of RING_DEPTH recent wind-speed increments. a record
// transaction (opcode 0) turns the counter reading into an 8-bit increment since the
// previous reading, adding counter_modulus on rollover, and stores it with the
// direction in the next ring slot; an evaluate transaction (opcode 1) acts once
// every slot has been written, scanning the ring for the minimum (from 150) and the
// first maximum, and reports that slot when max >= min + gust_threshold and it has
// not been reported before. every transaction gives exactly one result; no gust
// reads as all-zero fields. one transaction is worked on at a time: a record goes
// to load, an evaluate on a full ring through scan, drain, fetch, decide and load,
// the scan reading one ring entry per cycle from a single-read-port ram. the next
// transaction is taken while the previous result is stalled in the output register.
// the user must write configuration through cfg_we_i only while idle; not enforced.
module wind_gust_window_detector_core #(
  parameter int RING_DEPTH = gwd_pkg::RING_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [gwd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gwd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input transactions
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           opcode_i,
  input  logic [gwd_pkg::COUNT_W-1:0]    counter_reading_i,
  input  logic [gwd_pkg::DIR_W-1:0]      direction_reading_i,
  // result transactions
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           gust_found_o,
  output logic [gwd_pkg::SPEED_W-1:0]    gust_speed_o,
  output logic [gwd_pkg::DIR_W-1:0]      gust_direction_o,
  output logic [gwd_pkg::SLOT_OUT_W-1:0] gust_slot_o
);
  import gwd_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer: accept, scan, fetch the maximum's entry, decide, hand over
  gwd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .opcode_i   (opcode_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // ring ram, min/max scan, threshold test and output register
  gwd_datapath #(
    .RING_DEPTH(RING_DEPTH)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .counter_reading_i  (counter_reading_i),
    .direction_reading_i(direction_reading_i),
    .cmd_i              (cmd),
    .status_o           (status),
    .gust_found_o       (gust_found_o),
    .gust_speed_o       (gust_speed_o),
    .gust_direction_o   (gust_direction_o),
    .gust_slot_o        (gust_slot_o)
  );

endmodule

// ===== sv/gwd_checker.sv =====
module gwd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_we_i,
  input logic [gwd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [gwd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           opcode_i,
  input logic [gwd_pkg::COUNT_W-1:0]    counter_reading_i,
  input logic [gwd_pkg::DIR_W-1:0]      direction_reading_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic                           gust_found_o,
  input logic [gwd_pkg::SPEED_W-1:0]    gust_speed_o,
  input logic [gwd_pkg::DIR_W-1:0]      gust_direction_o,
  input logic [gwd_pkg::SLOT_OUT_W-1:0] gust_slot_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(gust_found_o)
      && $stable(gust_speed_o) && $stable(gust_direction_o) && $stable(gust_slot_o))
    else $error("stalled result changed");

  // no gust means all-zero fields
  a_no_gust_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !gust_found_o |->
      gust_speed_o == '0 && gust_direction_o == '0 && gust_slot_o == '0)
    else $error("fields not zero without a gust");

  // one transaction at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transaction taken while busy");

  // a reported gust never shows a zero speed
  a_gust_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && gust_found_o |-> gust_speed_o != '0)
    else $error("gust reported with zero speed");

endmodule

bind wind_gust_window_detector_core gwd_checker u_gwd_checker (.*);
